/* hw/rtl/tks_pkg.sv */
// tks_pkg: types, constants and compare function for the top-K score selector.
// Used by tks_front, tks_queue, tks_back and top_k_score_selector.
`timescale 1ns / 1ps

package tks_pkg;

    localparam int MAX_KEEP    = 8;
    localparam int MAX_ITEMS   = 65536;
    localparam int QUEUE_DEPTH = 4;

    localparam int SCORE_W = 32;
    localparam int INDEX_W = 16;
    localparam int KEEP_W  = 4;
    localparam int KEEP_RESET = 5;

    localparam int POS_W  = $clog2(MAX_ITEMS + 1);
    localparam int CNT_W  = $clog2(MAX_KEEP + 1);
    localparam int SLOT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int TOP_INDEX = ((MAX_ITEMS - 1) > 65535) ? 65535 : (MAX_ITEMS - 1);

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      is_final;
    } item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] best_score;
        logic        [INDEX_W-1:0] best_index;
        logic                      rank_last;
        logic                      index_overflow;
    } result_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [INDEX_W-1:0] index;
        logic                      is_final;
        logic                      overflow;
    } qentry_t;

    typedef struct packed {
        logic push;
        logic full;
    } qwr_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } qrd_ctl_t;

    typedef enum logic {
        BK_INSERT,
        BK_EMIT
    } back_state_t;

    // true if (sa, ia) ranks at or above (sb, ib)
    function automatic logic ranks_at_least(
        input logic signed [SCORE_W-1:0] sa,
        input logic        [INDEX_W-1:0] ia,
        input logic signed [SCORE_W-1:0] sb,
        input logic        [INDEX_W-1:0] ib
    );
        logic r;
        if (sa != sb)
            r = (sa > sb);
        else
            r = (ia >= ib);
        return r;
    endfunction

endpackage

/* hw/rtl/top_k_score_selector.sv */
// top_k_score_selector: streaming top-K selection over signed 16.16 scores.
// Instantiates tks_front, tks_queue and tks_back; depends on tks_pkg.
//
//  channel  | direction | transfer when        | payload
//  ---------+-----------+----------------------+-----------------------------
//  item     | in        | push && !full        | item_t   (score, is_final)
//  result   | out       | pop && !empty        | result_t (score, index, flags)
//  cfg      | in        | cfg_we               | cfg_data = keep_count
//
// Scores enter the queue at one per cycle while it has room; the back inserts one
// per cycle, while the queue is not empty, into an eight-entry sorted list (one
// compare per slot in parallel). After a final score, the top min(keep_count, list
// fill) results leave at one per cycle while the result register is empty or popped;
// the back takes no new score until the last of them is in the result register.
// Reset empties the queue and the list and sets keep_count to 5.
`timescale 1ns / 1ps

module top_k_score_selector
    import tks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  item_t             item,
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_data
);

    qwr_ctl_t q_wr;
    qrd_ctl_t q_rd;
    qentry_t  q_in;
    qentry_t  q_out;
    logic     q_full;
    logic     q_empty;

    assign full = q_full;

    tks_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_entry (q_in)
    );

    tks_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (q_in),
        .pop      (q_rd.pop),
        .full     (q_full),
        .empty    (q_empty),
        .rd_entry (q_out)
    );

    tks_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_empty  (q_empty),
        .q_entry  (q_out),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

/* hw/rtl/tks_front.sv */
// tks_front: assigns stream positions, saturates the index and tracks overflow.
// Depends on tks_pkg; feeds tks_queue.
`timescale 1ns / 1ps

module tks_front
    import tks_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  item_t    item,
    input  logic     q_full,
    output qwr_ctl_t q_wr,
    output qentry_t  q_entry
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic             sat;
    logic             take;

    assign sat  = (pos_reg > POS_W'(TOP_INDEX));
    assign take = push && !q_full;

    assign q_wr.push = take;
    assign q_wr.full = q_full;

    always_comb
    begin
        q_entry.score    = item.score;
        q_entry.index    = sat ? INDEX_W'(TOP_INDEX) : pos_reg[INDEX_W-1:0];
        q_entry.is_final = item.is_final;
        q_entry.overflow = ovf_reg || sat;
    end

    always_comb
    begin
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            if (item.is_final)
            begin
                pos_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                ovf_next = ovf_reg || sat;
                if (pos_reg < POS_W'(MAX_ITEMS))
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

/* hw/rtl/tks_queue.sv */
// tks_queue: short register queue between the front and the back.
// Depends on tks_pkg.
`timescale 1ns / 1ps

module tks_queue
    import tks_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  qwr_ctl_t wr,
    input  qentry_t  wr_entry,
    input  logic     pop,
    output logic     full,
    output logic     empty,
    output qentry_t  rd_entry
);

    qentry_t           slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* hw/rtl/tks_back.sv */
// tks_back: sorted insertion list, end-of-vector ranking readout and result register.
// Depends on tks_pkg; drains tks_queue.
`timescale 1ns / 1ps

module tks_back
    import tks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_data,
    input  logic              q_empty,
    input  qentry_t           q_entry,
    output qrd_ctl_t          q_rd,
    input  logic              pop,
    output logic              empty,
    output result_t           result
);

    back_state_t state_reg, state_next;

    logic signed [SCORE_W-1:0] score_reg [MAX_KEEP];
    logic signed [SCORE_W-1:0] score_next [MAX_KEEP];
    logic        [INDEX_W-1:0] index_reg [MAX_KEEP];
    logic        [INDEX_W-1:0] index_next [MAX_KEEP];

    logic [CNT_W-1:0]  filled_reg, filled_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [SLOT_W-1:0] emit_reg, emit_next;
    logic              ovf_reg, ovf_next;
    logic [KEEP_W-1:0] keep_reg, keep_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic             insert_go;
    logic             emit_go;
    logic             emit_last;
    logic [MAX_KEEP-1:0] goes_before;
    logic [CNT_W-1:0] filled_ins;
    logic [CNT_W-1:0] keep_clamp;
    logic [CNT_W-1:0] k_calc;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INSERT:
                if (insert_go && q_entry.is_final && (k_calc != '0))
                    state_next = BK_EMIT;
            BK_EMIT:
                if (emit_go && emit_last)
                    state_next = BK_INSERT;
            default:
                state_next = BK_INSERT;
        endcase
    end

    always_comb
    begin
        insert_go = 1'b0;
        emit_go   = 1'b0;
        unique case (state_reg)
            BK_INSERT: insert_go = !q_empty;
            BK_EMIT:   emit_go   = !out_valid_reg || pop;
            default:
            begin
                insert_go = 1'b0;
                emit_go   = 1'b0;
            end
        endcase
    end

    assign q_rd.pop   = insert_go;
    assign q_rd.empty = q_empty;
    assign emit_last  = ((CNT_W'(emit_reg) + CNT_W'(1)) == k_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_KEEP; j++)
            goes_before[j] = (CNT_W'(j) >= filled_reg)
                || ranks_at_least(q_entry.score, q_entry.index, score_reg[j], index_reg[j]);
    end

    assign filled_ins = (filled_reg == CNT_W'(MAX_KEEP)) ? filled_reg
                      : filled_reg + CNT_W'(1);
    assign keep_clamp = (32'(keep_reg) > 32'(MAX_KEEP)) ? CNT_W'(MAX_KEEP)
                      : CNT_W'(keep_reg);
    assign k_calc     = (keep_clamp > filled_ins) ? filled_ins : keep_clamp;

    always_comb
    begin
        score_next[0] = score_reg[0];
        index_next[0] = index_reg[0];
        if (insert_go && goes_before[0])
        begin
            score_next[0] = q_entry.score;
            index_next[0] = q_entry.index;
        end
        for (int j = 1; j < MAX_KEEP; j++)
        begin
            score_next[j] = score_reg[j];
            index_next[j] = index_reg[j];
            if (insert_go && goes_before[j])
            begin
                if (!goes_before[j-1])
                begin
                    score_next[j] = q_entry.score;
                    index_next[j] = q_entry.index;
                end
                else
                begin
                    score_next[j] = score_reg[j-1];
                    index_next[j] = index_reg[j-1];
                end
            end
        end
    end

    always_comb
    begin
        filled_next    = filled_reg;
        k_next         = k_reg;
        emit_next      = emit_reg;
        ovf_next       = ovf_reg;
        keep_next      = cfg_we ? cfg_data : keep_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (insert_go)
        begin
            filled_next = filled_ins;
            if (q_entry.is_final)
            begin
                ovf_next  = q_entry.overflow;
                k_next    = k_calc;
                emit_next = '0;
                if (k_calc == '0)
                    filled_next = '0;
            end
        end

        if (emit_go)
        begin
            out_valid_next          = 1'b1;
            out_next.best_score     = score_reg[emit_reg];
            out_next.best_index     = index_reg[emit_reg];
            out_next.rank_last      = emit_last;
            out_next.index_overflow = ovf_reg;
            if (emit_last)
            begin
                emit_next   = '0;
                filled_next = '0;
            end
            else
            begin
                emit_next = emit_reg + SLOT_W'(1);
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_KEEP; j++)
        begin
            score_reg[j] <= score_next[j];
            index_reg[j] <= index_next[j];
        end
        out_reg <= out_next;
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INSERT;
            filled_reg    <= '0;
            k_reg         <= '0;
            emit_reg      <= '0;
            keep_reg      <= KEEP_W'(KEEP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            k_reg         <= k_next;
            emit_reg      <= emit_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_W'(MAX_KEEP))
        else $error("list fill beyond depth");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EMIT |-> (k_reg != '0) && (k_reg <= filled_reg)
                                 && (CNT_W'(emit_reg) < k_reg))
        else $error("readout position outside ranked run");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && emit_last |=> (filled_reg == '0) && (state_reg == BK_INSERT))
        else $error("list not cleared after final result");

    a_no_drain_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EMIT |-> !q_rd.pop)
        else $error("queue drained during readout");

endmodule
